### sv/efla_pkg.sv
`default_nettype none
package efla_pkg;

    // Build defaults
    localparam int HEAP_BYTES_DEF   = 262144;
    localparam int EXTEND_CHUNK_DEF = 4096;

    // Boundary-tag encoding
    localparam logic [31:0] MIN_BLOCK = 32'd24;
    localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
    localparam logic [31:0] ALLOC_BIT = 32'd1;

    // Fixed heap layout after reset
    localparam logic [31:0] PRO_HDR  = 32'd4;
    localparam logic [31:0] PRO_FTR  = 32'd24;
    localparam logic [31:0] PRO_END  = 32'd28;
    localparam logic [31:0] PRO_PAY  = 32'd8;
    localparam logic [31:0] BASE_TOP = 32'd48;

    // Operation codes
    typedef enum logic [1:0] {
        K_ALLOC   = 2'd0,
        K_RELEASE = 2'd1,
        K_RESIZE  = 2'd2
    } t_kind;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    // Heap memory access, byte addresses
    typedef struct packed {
        logic        we;
        logic [31:0] waddr;
        logic [31:0] wdata;
        logic [31:0] raddr;
    } t_mem_req;

    // One result transaction
    typedef struct packed {
        logic [17:0] result_address;
        logic [17:0] copy_from;
        logic [18:0] copy_bytes;
        logic [1:0]  status;
    } t_result;

endpackage
`default_nettype wire

### sv/efla_mem.sv
`default_nettype none
module efla_mem #(
    parameter int HEAP_BYTES = efla_pkg::HEAP_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire efla_pkg::t_mem_req i_req,
    output logic [31:0]            o_rdata
);
    localparam int WORDS = HEAP_BYTES / 4;
    localparam int AW    = $clog2(WORDS);

    logic [31:0] r_mem [WORDS];
    logic [31:0] r_q;
    logic        r_rok;
    logic        w_wok;
    logic        w_rok;

    // Accesses outside the heap: writes dropped, reads give zero
    assign w_wok = i_req.waddr[31:2] < 30'(WORDS);
    assign w_rok = i_req.raddr[31:2] < 30'(WORDS);

    always_ff @(posedge i_clk) begin
        if (i_req.we && w_wok) begin
            r_mem[i_req.waddr[AW+1:2]] <= i_req.wdata;
        end
        r_q   <= r_mem[i_req.raddr[AW+1:2]];
        r_rok <= w_rok;
    end

    assign o_rdata = r_rok ? r_q : 32'd0;

endmodule
`default_nettype wire

### sv/efla_seq.sv
`default_nettype none
module efla_seq #(
    parameter int HEAP_BYTES   = efla_pkg::HEAP_BYTES_DEF,
    parameter int EXTEND_CHUNK = efla_pkg::EXTEND_CHUNK_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_kind,
    input  wire logic [18:0]        i_req,
    input  wire logic [17:0]        i_addr,
    input  wire logic               i_out_free,
    output logic                    o_busy,
    output logic                    o_done,
    output efla_pkg::t_result       o_result,
    output efla_pkg::t_mem_req      o_mem,
    input  wire logic [31:0]        i_rdata
);
    localparam int WORDS      = HEAP_BYTES / 4;
    localparam int CW         = $clog2(WORDS);
    localparam int WALK_LIMIT = HEAP_BYTES / 8 + 2;
    localparam int FW         = $clog2(WALK_LIMIT + 1);
    localparam int NS         = 54;
    localparam logic [NS-1:0] ST1 = 1;

    typedef enum logic [NS-1:0] {
        S_CLR  = ST1 << 0,  S_IN0  = ST1 << 1,  S_IN1  = ST1 << 2,  S_IN2  = ST1 << 3,
        S_IDLE = ST1 << 4,  S_DISP = ST1 << 5,  S_AKR  = ST1 << 6,  S_AL0  = ST1 << 7,
        S_FF0  = ST1 << 8,  S_FF1  = ST1 << 9,  S_FF2  = ST1 << 10, S_ALG  = ST1 << 11,
        S_ALGR = ST1 << 12, S_GR0  = ST1 << 13, S_GR1  = ST1 << 14, S_GR2  = ST1 << 15,
        S_GR3  = ST1 << 16, S_CV0  = ST1 << 17, S_CV1  = ST1 << 18, S_CV2  = ST1 << 19,
        S_CV3  = ST1 << 20, S_CV4  = ST1 << 21, S_CV4B = ST1 << 22, S_CV5  = ST1 << 23,
        S_CV6  = ST1 << 24, S_TG0  = ST1 << 25, S_TG1  = ST1 << 26, S_TG2  = ST1 << 27,
        S_UL0  = ST1 << 28, S_UL1  = ST1 << 29, S_UL2  = ST1 << 30, S_UL3  = ST1 << 31,
        S_UL4  = ST1 << 32, S_UL5  = ST1 << 33, S_MG0  = ST1 << 34, S_MG1  = ST1 << 35,
        S_MG2  = ST1 << 36, S_MG3  = ST1 << 37, S_MG4  = ST1 << 38, S_MG5  = ST1 << 39,
        S_MG6  = ST1 << 40, S_MGT  = ST1 << 41, S_MT0  = ST1 << 42, S_MT1  = ST1 << 43,
        S_MT2  = ST1 << 44, S_RL0  = ST1 << 45, S_RL1  = ST1 << 46, S_RL2  = ST1 << 47,
        S_RZ0  = ST1 << 48, S_RZ1  = ST1 << 49, S_RZ2  = ST1 << 50, S_RZ3  = ST1 << 51,
        S_RZ4  = ST1 << 52, S_FIN  = ST1 << 53
    } t_state;

    t_state r_state, n_state;
    // Return points of the shared routines
    t_state r_ret_tag, n_ret_tag, r_ret_unl, n_ret_unl, r_ret_mrg, n_ret_mrg;
    t_state r_ret_rel, n_ret_rel, r_ret_alloc, n_ret_alloc, r_ret_grow, n_ret_grow;

    logic [CW-1:0] r_clr, n_clr;
    logic [31:0]   r_head, n_head, r_top, n_top;
    logic [1:0]    r_kind, n_kind;
    logic [18:0]   r_req, n_req;
    logic [31:0]   r_addr, n_addr, r_need, n_need, r_old, n_old;
    logic [31:0]   r_fp, n_fp;
    logic [FW-1:0] r_fn, n_fn;
    logic [31:0]   r_gb, n_gb, r_gp, n_gp, r_gsz, n_gsz, r_gres, n_gres;
    logic [31:0]   r_ap, n_ap, r_have, n_have, r_ares, n_ares;
    logic [31:0]   r_tp, n_tp, r_tv, n_tv;
    logic [31:0]   r_up, n_up, r_ub, n_ub, r_un, n_un;
    logic [31:0]   r_mp, n_mp, r_ml, n_ml, r_mr, n_mr, r_msz, n_msz, r_lsz, n_lsz;
    logic          r_lu, n_lu;
    logic [31:0]   r_rp, n_rp;
    logic [17:0]   r_res, n_res, r_from, n_from;
    logic [18:0]   r_cnt, n_cnt;
    logic [1:0]    r_st, n_st;

    logic [31:0] w_rsz;
    logic [31:0] w_need;
    logic [31:0] w_gsz;
    logic [32:0] w_gend;

    // Block size for a payload request: align to 8, add tags, floor at minimum
    always_comb begin
        w_need = (({13'd0, i_req} + 32'd7) & efla_pkg::SIZE_MASK) + 32'd8;
        if (w_need < efla_pkg::MIN_BLOCK) begin
            w_need = efla_pkg::MIN_BLOCK;
        end
    end

    // Growth size: whole even word count, floor at minimum block
    always_comb begin
        w_gsz = (r_gb & efla_pkg::SIZE_MASK) + (r_gb[2] ? 32'd8 : 32'd0);
        if (w_gsz < efla_pkg::MIN_BLOCK) begin
            w_gsz = efla_pkg::MIN_BLOCK;
        end
        w_gend = {1'b0, r_top} + {1'b0, w_gsz};
    end

    assign w_rsz = i_rdata & efla_pkg::SIZE_MASK;

    // Sequencer: each read issues in one state and is used in the next
    always_comb begin
        n_state = r_state;   n_ret_tag = r_ret_tag; n_ret_unl = r_ret_unl;
        n_ret_mrg = r_ret_mrg; n_ret_rel = r_ret_rel; n_ret_alloc = r_ret_alloc;
        n_ret_grow = r_ret_grow;
        n_clr = r_clr;   n_head = r_head; n_top = r_top;
        n_kind = r_kind; n_req = r_req;   n_addr = r_addr; n_need = r_need; n_old = r_old;
        n_fp = r_fp;     n_fn = r_fn;
        n_gb = r_gb;     n_gp = r_gp;     n_gsz = r_gsz;   n_gres = r_gres;
        n_ap = r_ap;     n_have = r_have; n_ares = r_ares;
        n_tp = r_tp;     n_tv = r_tv;
        n_up = r_up;     n_ub = r_ub;     n_un = r_un;
        n_mp = r_mp;     n_ml = r_ml;     n_mr = r_mr;     n_msz = r_msz; n_lsz = r_lsz;
        n_lu = r_lu;     n_rp = r_rp;
        n_res = r_res;   n_from = r_from; n_cnt = r_cnt;   n_st = r_st;
        o_mem = '0;
        o_done = 1'b0;

        unique case (r_state)
            // Clearing pass, fixed layout and the first heap growth
            S_CLR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = 32'({r_clr, 2'b00});
                n_clr = r_clr + 1'b1;
                if (r_clr == CW'(WORDS - 1)) begin
                    n_state = S_IN0;
                end
            end
            S_IN0: begin
                o_mem.we = 1'b1; o_mem.waddr = efla_pkg::PRO_HDR;
                o_mem.wdata = efla_pkg::MIN_BLOCK | efla_pkg::ALLOC_BIT;
                n_state = S_IN1;
            end
            S_IN1: begin
                o_mem.we = 1'b1; o_mem.waddr = efla_pkg::PRO_FTR;
                o_mem.wdata = efla_pkg::MIN_BLOCK | efla_pkg::ALLOC_BIT;
                n_state = S_IN2;
            end
            S_IN2: begin
                o_mem.we = 1'b1; o_mem.waddr = efla_pkg::PRO_END;
                o_mem.wdata = efla_pkg::ALLOC_BIT;
                n_head = efla_pkg::PRO_PAY;
                n_top  = efla_pkg::BASE_TOP;
                n_gb   = 32'(EXTEND_CHUNK);
                n_ret_grow = S_IDLE;
                n_state = S_GR0;
            end

            // Take a transaction
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_kind; n_req = i_req; n_addr = {14'd0, i_addr};
                    n_need = w_need;
                    n_res = '0; n_from = '0; n_cnt = '0; n_st = efla_pkg::ST_DONE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_kind)
                    efla_pkg::K_ALLOC: begin
                        if (r_req == '0) begin
                            n_st = efla_pkg::ST_ZERO; n_state = S_FIN;
                        end else begin
                            n_ret_alloc = S_AKR; n_state = S_AL0;
                        end
                    end
                    efla_pkg::K_RELEASE: begin
                        n_rp = r_addr; n_ret_rel = S_FIN; n_state = S_RL0;
                    end
                    efla_pkg::K_RESIZE: begin
                        if (r_req == '0) begin
                            n_st = efla_pkg::ST_ZERO;
                            n_rp = r_addr; n_ret_rel = S_FIN; n_state = S_RL0;
                        end else if (r_addr == '0) begin
                            n_ret_alloc = S_AKR; n_state = S_AL0;
                        end else begin
                            n_state = S_RZ0;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_AKR: begin
                n_res = r_ares[17:0];
                n_st  = (r_ares != '0) ? efla_pkg::ST_DONE : efla_pkg::ST_NOSPACE;
                n_state = S_FIN;
            end

            // Allocate: first-fit walk of the free list, growing the heap when no block fits
            S_AL0: begin
                n_fp = r_head; n_fn = '0; n_state = S_FF0;
            end
            S_FF0: begin
                o_mem.raddr = r_fp - 32'd4; n_state = S_FF1;
            end
            S_FF1: begin
                if (r_fn >= FW'(WALK_LIMIT) || i_rdata[0]) begin
                    n_state = S_ALG;
                end else if (r_need <= w_rsz) begin
                    n_ap = r_fp;
                    n_state = (r_fp == '0) ? S_ALG : S_CV0;
                end else begin
                    o_mem.raddr = r_fp + 32'd8; n_state = S_FF2;
                end
            end
            S_FF2: begin
                n_fp = i_rdata; n_fn = r_fn + 1'b1; n_state = S_FF0;
            end
            S_ALG: begin
                n_gb = (r_need > 32'(EXTEND_CHUNK)) ? r_need : 32'(EXTEND_CHUNK);
                n_ret_grow = S_ALGR; n_state = S_GR0;
            end
            S_ALGR: begin
                if (r_gres == '0) begin
                    n_ares = '0; n_state = r_ret_alloc;
                end else begin
                    n_ap = r_gres; n_state = S_CV0;
                end
            end

            // Grow the heap at its top
            S_GR0: begin
                if (w_gend > 33'(HEAP_BYTES)) begin
                    n_gres = '0; n_state = r_ret_grow;
                end else begin
                    n_gp = r_top; n_gsz = w_gsz; n_top = w_gend[31:0];
                    o_mem.we = 1'b1; o_mem.waddr = r_top - 32'd4; o_mem.wdata = w_gsz;
                    n_state = S_GR1;
                end
            end
            S_GR1: begin
                o_mem.we = 1'b1; o_mem.waddr = r_gp + r_gsz - 32'd8; o_mem.wdata = r_gsz;
                n_state = S_GR2;
            end
            S_GR2: begin
                o_mem.we = 1'b1; o_mem.waddr = r_gp + r_gsz - 32'd4;
                o_mem.wdata = efla_pkg::ALLOC_BIT;
                n_mp = r_gp; n_ret_mrg = S_GR3; n_state = S_MG0;
            end
            S_GR3: begin
                n_gres = r_mp; n_state = r_ret_grow;
            end

            // Carve the chosen block, splitting off a large enough tail
            S_CV0: begin
                o_mem.raddr = r_ap - 32'd4; n_state = S_CV1;
            end
            S_CV1: begin
                n_have = w_rsz; n_tp = r_ap; n_ret_tag = S_CV5;
                n_tv = w_rsz | efla_pkg::ALLOC_BIT;
                if (w_rsz - r_need >= efla_pkg::MIN_BLOCK) begin
                    n_tv = r_need | efla_pkg::ALLOC_BIT; n_ret_tag = S_CV2;
                end
                n_state = S_TG0;
            end
            S_CV2: begin
                n_up = r_ap; n_ret_unl = S_CV3; n_state = S_UL0;
            end
            S_CV3: begin
                o_mem.we = 1'b1; o_mem.waddr = r_ap + r_need - 32'd4;
                o_mem.wdata = r_have - r_need;
                n_state = S_CV4;
            end
            S_CV4: begin
                n_tp = r_ap + r_need; n_tv = r_have - r_need;
                n_ret_tag = S_CV4B; n_state = S_TG0;
            end
            S_CV4B: begin
                n_mp = r_ap + r_need; n_ret_mrg = S_CV6; n_state = S_MG0;
            end
            S_CV5: begin
                n_up = r_ap; n_ret_unl = S_CV6; n_state = S_UL0;
            end
            S_CV6: begin
                n_ares = r_ap; n_state = r_ret_alloc;
            end

            // Header write, then footer at the size just written
            S_TG0: begin
                o_mem.we = 1'b1; o_mem.waddr = r_tp - 32'd4; o_mem.wdata = r_tv;
                n_state = S_TG1;
            end
            S_TG1: begin
                o_mem.raddr = r_tp - 32'd4; n_state = S_TG2;
            end
            S_TG2: begin
                o_mem.we = 1'b1; o_mem.waddr = r_tp + w_rsz - 32'd8; o_mem.wdata = r_tv;
                n_state = r_ret_tag;
            end

            // Unlink from the free list; links are read again after the first write
            S_UL0: begin
                o_mem.raddr = r_up; n_state = S_UL1;
            end
            S_UL1: begin
                n_ub = i_rdata; o_mem.raddr = r_up + 32'd8; n_state = S_UL2;
            end
            S_UL2: begin
                if (r_ub != '0) begin
                    o_mem.we = 1'b1; o_mem.waddr = r_ub + 32'd8; o_mem.wdata = i_rdata;
                end else begin
                    n_head = i_rdata;
                end
                n_state = S_UL3;
            end
            S_UL3: begin
                o_mem.raddr = r_up + 32'd8; n_state = S_UL4;
            end
            S_UL4: begin
                n_un = i_rdata; o_mem.raddr = r_up; n_state = S_UL5;
            end
            S_UL5: begin
                o_mem.we = 1'b1; o_mem.waddr = r_un; o_mem.wdata = i_rdata;
                n_state = r_ret_unl;
            end

            // Coalesce with free neighbours and push at the list head
            S_MG0: begin
                o_mem.raddr = r_mp - 32'd8; n_state = S_MG1;
            end
            S_MG1: begin
                n_ml = r_mp - w_rsz; o_mem.raddr = r_mp - 32'd4; n_state = S_MG2;
            end
            S_MG2: begin
                n_msz = w_rsz; n_mr = r_mp + w_rsz;
                o_mem.raddr = r_ml - 32'd4; n_state = S_MG3;
            end
            S_MG3: begin
                n_lsz = w_rsz; o_mem.raddr = r_ml + w_rsz - 32'd8; n_state = S_MG4;
            end
            S_MG4: begin
                n_lu = i_rdata[0] || (r_ml == r_mp);
                o_mem.raddr = r_mr - 32'd4; n_state = S_MG5;
            end
            S_MG5: begin
                if (r_lu && !i_rdata[0]) begin
                    n_msz = r_msz + w_rsz;
                    n_up = r_mr; n_ret_unl = S_MGT; n_state = S_UL0;
                end else if (!r_lu && i_rdata[0]) begin
                    n_msz = r_msz + r_lsz; n_mp = r_ml;
                    n_up = r_ml; n_ret_unl = S_MGT; n_state = S_UL0;
                end else if (!r_lu) begin
                    n_msz = r_msz + r_lsz + w_rsz; n_mp = r_ml;
                    n_up = r_ml; n_ret_unl = S_MG6; n_state = S_UL0;
                end else begin
                    n_state = S_MT0;
                end
            end
            S_MG6: begin
                n_up = r_mr; n_ret_unl = S_MGT; n_state = S_UL0;
            end
            S_MGT: begin
                n_tp = r_mp; n_tv = r_msz; n_ret_tag = S_MT0; n_state = S_TG0;
            end
            S_MT0: begin
                o_mem.we = 1'b1; o_mem.waddr = r_mp + 32'd8; o_mem.wdata = r_head;
                n_state = S_MT1;
            end
            S_MT1: begin
                o_mem.we = 1'b1; o_mem.waddr = r_head; o_mem.wdata = r_mp;
                n_state = S_MT2;
            end
            S_MT2: begin
                o_mem.we = 1'b1; o_mem.waddr = r_mp; o_mem.wdata = '0;
                n_head = r_mp; n_state = r_ret_mrg;
            end

            // Release: clear the used bit, then coalesce
            S_RL0: begin
                if (r_rp == '0) begin
                    n_state = r_ret_rel;
                end else begin
                    o_mem.raddr = r_rp - 32'd4; n_state = S_RL1;
                end
            end
            S_RL1: begin
                n_tp = r_rp; n_tv = w_rsz; n_ret_tag = S_RL2; n_state = S_TG0;
            end
            S_RL2: begin
                n_mp = r_rp; n_ret_mrg = r_ret_rel; n_state = S_MG0;
            end

            // Resize of a live block
            S_RZ0: begin
                o_mem.raddr = r_addr - 32'd4; n_state = S_RZ1;
            end
            S_RZ1: begin
                n_old = w_rsz;
                if (r_need <= w_rsz) begin
                    n_res = r_addr[17:0];
                    if (w_rsz - r_need > efla_pkg::MIN_BLOCK) begin
                        n_tp = r_addr; n_tv = r_need | efla_pkg::ALLOC_BIT;
                        n_ret_tag = S_RZ2; n_state = S_TG0;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_ret_alloc = S_RZ4; n_state = S_AL0;
                end
            end
            S_RZ2: begin
                o_mem.we = 1'b1; o_mem.waddr = r_addr + r_need - 32'd4;
                o_mem.wdata = (r_old - r_need) | efla_pkg::ALLOC_BIT;
                n_state = S_RZ3;
            end
            S_RZ3: begin
                n_rp = r_addr + r_need; n_ret_rel = S_FIN; n_state = S_RL0;
            end
            S_RZ4: begin
                if (r_ares == '0) begin
                    n_st = efla_pkg::ST_NOSPACE; n_state = S_FIN;
                end else begin
                    n_res  = r_ares[17:0];
                    n_from = r_addr[17:0];
                    n_cnt  = ({13'd0, r_req} < r_old) ? r_req : r_old[18:0];
                    n_rp = r_addr; n_ret_rel = S_FIN; n_state = S_RL0;
                end
            end

            // Hand the result to the output register
            S_FIN: begin
                if (i_out_free) begin
                    o_done = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ret_tag <= n_ret_tag; r_ret_unl <= n_ret_unl; r_ret_mrg <= n_ret_mrg;
        r_ret_rel <= n_ret_rel; r_ret_alloc <= n_ret_alloc; r_ret_grow <= n_ret_grow;
        r_head <= n_head; r_top <= n_top;
        r_kind <= n_kind; r_req <= n_req; r_addr <= n_addr; r_need <= n_need; r_old <= n_old;
        r_fp <= n_fp; r_fn <= n_fn;
        r_gb <= n_gb; r_gp <= n_gp; r_gsz <= n_gsz; r_gres <= n_gres;
        r_ap <= n_ap; r_have <= n_have; r_ares <= n_ares;
        r_tp <= n_tp; r_tv <= n_tv;
        r_up <= n_up; r_ub <= n_ub; r_un <= n_un;
        r_mp <= n_mp; r_ml <= n_ml; r_mr <= n_mr; r_msz <= n_msz; r_lsz <= n_lsz;
        r_lu <= n_lu; r_rp <= n_rp;
        r_res <= n_res; r_from <= n_from; r_cnt <= n_cnt; r_st <= n_st;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_result.result_address = r_res;
    assign o_result.copy_from      = r_from;
    assign o_result.copy_bytes     = r_cnt;
    assign o_result.status         = r_st;

endmodule
`default_nettype wire

### sv/explicit_free_list_allocator.sv
`default_nettype none
// First-fit heap allocator (allocate, release, resize) keeping all boundary tags
// and free-list links in a word memory of HEAP_BYTES bytes with a registered
// read. One transaction at a time, run by a sequencer that issues each memory
// read one state ahead of its use. A request that changes nothing (zero-size
// allocate, release of none, unknown kind) finishes soonest, an allocate served
// from the free list without a split sooner than a resize that grows the heap,
// splits and moves, and each free block skipped in the list walk adds its own
// read states. Coalescing time is set by how many free neighbors are unlinked.
// After each result the sequencer returns to idle, where the next request is
// taken. After reset a clearing pass over all HEAP_BYTES/4 words and the setup
// of the fixed layout and first heap growth run before the first transaction is
// taken. A finished result sits in an output register, so the next request is
// taken while it waits. Resize that moves returns the old offset and copy
// length; the payload copy itself is left to the user.
module explicit_free_list_allocator #(
    parameter int HEAP_BYTES   = efla_pkg::HEAP_BYTES_DEF,
    parameter int EXTEND_CHUNK = efla_pkg::EXTEND_CHUNK_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [18:0] i_request_bytes,
    input  wire logic [17:0] i_block_address,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [17:0]      o_result_address,
    output logic [17:0]      o_copy_from,
    output logic [18:0]      o_copy_bytes,
    output logic [1:0]       o_status
);
    efla_pkg::t_mem_req w_mem;
    efla_pkg::t_result  w_result;
    efla_pkg::t_result  r_out;
    logic [31:0]        w_rdata;
    logic               w_busy;
    logic               w_done;
    logic               w_start;
    logic               w_out_free;
    logic               r_out_valid;

    assign o_in_stall = w_busy;
    assign w_start    = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;

    efla_seq #(
        .HEAP_BYTES   (HEAP_BYTES),
        .EXTEND_CHUNK (EXTEND_CHUNK)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_kind     (i_kind),
        .i_req      (i_request_bytes),
        .i_addr     (i_block_address),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata)
    );

    efla_mem #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out.result_address;
    assign o_copy_from      = r_out.copy_from;
    assign o_copy_bytes     = r_out.copy_bytes;
    assign o_status         = r_out.status;

endmodule
`default_nettype wire

### bench/explicit_free_list_allocator_tb.sv
`timescale 1ns / 100ps
module explicit_free_list_allocator_tb;

    localparam int          HEAP_BYTES   = efla_pkg::HEAP_BYTES_DEF;
    localparam int          EXTEND_CHUNK = efla_pkg::EXTEND_CHUNK_DEF;
    localparam int          WORD_COUNT   = HEAP_BYTES / 4;
    localparam int          WALK_LIMIT   = HEAP_BYTES / 8 + 2;
    localparam logic [1:0]  K_UNKNOWN    = 2'd3;
    localparam int          CYCLE_LIMIT  = 6000000;
    localparam int          MAX_LIVE     = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = 2'd0;
    logic [18:0] i_request_bytes = 19'd0;
    logic [17:0] i_block_address = 18'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [17:0] o_result_address;
    logic [17:0] o_copy_from;
    logic [18:0] o_copy_bytes;
    logic [1:0]  o_status;

    explicit_free_list_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_address(o_result_address),
        .o_copy_from     (o_copy_from),
        .o_copy_bytes    (o_copy_bytes),
        .o_status        (o_status)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow heap state
    bit [31:0]   heap_mem [WORD_COUNT];
    bit [31:0]   list_head;
    bit [31:0]   heap_end;

    efla_pkg::t_result expected_q[$];
    int unsigned live_blocks[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycles = 0;

    function automatic bit [31:0] mem_rd(bit [31:0] a);
        bit [31:0] i;
        i = a >> 2;
        return (i < WORD_COUNT) ? heap_mem[i] : 32'd0;
    endfunction

    function automatic void mem_wr(bit [31:0] a, bit [31:0] v);
        bit [31:0] i;
        i = a >> 2;
        if (i < WORD_COUNT) heap_mem[i] = v;
    endfunction

    function automatic bit [31:0] tag_size(bit [31:0] p);
        return mem_rd(p - 4) & efla_pkg::SIZE_MASK;
    endfunction

    function automatic bit [31:0] tag_used(bit [31:0] p);
        return mem_rd(p - 4) & efla_pkg::ALLOC_BIT;
    endfunction

    function automatic void write_tags(bit [31:0] p, bit [31:0] sz, bit [31:0] used);
        mem_wr(p - 4, sz | used);
        mem_wr(p + tag_size(p) - 8, sz | used);
    endfunction

    function automatic void list_unlink(bit [31:0] p);
        bit [31:0] prev;
        prev = mem_rd(p);
        if (prev != 0) mem_wr(prev + 8, mem_rd(p + 8));
        else list_head = mem_rd(p + 8);
        mem_wr(mem_rd(p + 8), mem_rd(p));
    endfunction

    // Merge with free neighbors, push result on list head
    function automatic bit [31:0] coalesce(bit [31:0] p);
        bit [31:0] left, right, sz;
        bit        left_used, right_used;
        left       = p - (mem_rd(p - 8) & efla_pkg::SIZE_MASK);
        right      = p + tag_size(p);
        left_used  = ((mem_rd(left + tag_size(left) - 8) & efla_pkg::ALLOC_BIT) != 0)
                     || left == p;
        right_used = tag_used(right) != 0;
        sz         = tag_size(p);
        if (left_used && !right_used) begin
            sz += tag_size(right);
            list_unlink(right);
            write_tags(p, sz, 0);
        end else if (!left_used && right_used) begin
            sz += tag_size(left);
            p = left;
            list_unlink(p);
            write_tags(p, sz, 0);
        end else if (!left_used && !right_used) begin
            sz += tag_size(left) + tag_size(right);
            list_unlink(left);
            list_unlink(right);
            p = left;
            write_tags(p, sz, 0);
        end
        mem_wr(p + 8, list_head);
        mem_wr(list_head, p);
        mem_wr(p, 0);
        list_head = p;
        return p;
    endfunction

    function automatic bit [31:0] heap_grow(bit [31:0] bytes);
        bit [31:0] w, sz, p;
        w = bytes / 4;
        if (w[0]) w++;
        sz = w * 4;
        if (sz < efla_pkg::MIN_BLOCK) sz = efla_pkg::MIN_BLOCK;
        if (64'(heap_end) + 64'(sz) > 64'(HEAP_BYTES)) return 0;
        p = heap_end;
        heap_end += sz;
        mem_wr(p - 4, sz);
        mem_wr(p + sz - 8, sz);
        mem_wr(p + sz - 4, efla_pkg::ALLOC_BIT);
        return coalesce(p);
    endfunction

    function automatic void split_block(bit [31:0] p, bit [31:0] need);
        bit [31:0] have;
        have = tag_size(p);
        if (have - need >= efla_pkg::MIN_BLOCK) begin
            write_tags(p, need, efla_pkg::ALLOC_BIT);
            list_unlink(p);
            p += need;
            mem_wr(p - 4, have - need);
            write_tags(p, have - need, 0);
            void'(coalesce(p));
        end else begin
            write_tags(p, have, efla_pkg::ALLOC_BIT);
            list_unlink(p);
        end
    endfunction

    function automatic bit [31:0] fit_search(bit [31:0] need);
        bit [31:0] p;
        p = list_head;
        for (int n = 0; n < WALK_LIMIT && tag_used(p) == 0; n++) begin
            if (need <= tag_size(p)) return p;
            p = mem_rd(p + 8);
        end
        return 0;
    endfunction

    function automatic bit [31:0] block_need(bit [31:0] req);
        bit [31:0] n;
        n = ((req + 7) & efla_pkg::SIZE_MASK) + 8;
        return (n < efla_pkg::MIN_BLOCK) ? efla_pkg::MIN_BLOCK : n;
    endfunction

    function automatic bit [31:0] heap_alloc(bit [31:0] req);
        bit [31:0] need, p;
        need = block_need(req);
        p = fit_search(need);
        if (p == 0) begin
            p = heap_grow((need > 32'(EXTEND_CHUNK)) ? need : 32'(EXTEND_CHUNK));
            if (p == 0) return 0;
        end
        split_block(p, need);
        return p;
    endfunction

    function automatic void heap_free(bit [31:0] p);
        if (p == 0) return;
        write_tags(p, tag_size(p), 0);
        void'(coalesce(p));
    endfunction

    function automatic void heap_reset();
        foreach (heap_mem[i]) heap_mem[i] = 0;
        mem_wr(efla_pkg::PRO_HDR, efla_pkg::MIN_BLOCK | efla_pkg::ALLOC_BIT);
        mem_wr(efla_pkg::PRO_FTR, efla_pkg::MIN_BLOCK | efla_pkg::ALLOC_BIT);
        mem_wr(efla_pkg::PRO_END, efla_pkg::ALLOC_BIT);
        list_head = efla_pkg::PRO_PAY;
        heap_end  = efla_pkg::BASE_TOP;
        void'(heap_grow(32'(EXTEND_CHUNK)));
    endfunction

    // Expected result of one request, updates the shadow heap
    function automatic efla_pkg::t_result predict_op(logic [1:0] kind, bit [31:0] req,
                                                     bit [31:0] addr);
        bit [31:0] res, from, cnt, need, old;
        logic [1:0] st;
        efla_pkg::t_result r;
        res = 0; from = 0; cnt = 0; st = efla_pkg::ST_DONE;
        if (kind == efla_pkg::K_ALLOC) begin
            if (req == 0) st = efla_pkg::ST_ZERO;
            else begin
                res = heap_alloc(req);
                st = (res != 0) ? efla_pkg::ST_DONE : efla_pkg::ST_NOSPACE;
            end
        end else if (kind == efla_pkg::K_RELEASE) begin
            heap_free(addr);
        end else if (kind == efla_pkg::K_RESIZE) begin
            if (req == 0) begin
                heap_free(addr);
                st = efla_pkg::ST_ZERO;
            end else if (addr == 0) begin
                res = heap_alloc(req);
                st = (res != 0) ? efla_pkg::ST_DONE : efla_pkg::ST_NOSPACE;
            end else begin
                need = block_need(req);
                old  = tag_size(addr);
                if (need <= old) begin
                    // shrink in place, tail freed only when it is big enough
                    if (old - need > efla_pkg::MIN_BLOCK) begin
                        write_tags(addr, need, efla_pkg::ALLOC_BIT);
                        mem_wr(addr + need - 4, (old - need) | efla_pkg::ALLOC_BIT);
                        heap_free(addr + need);
                    end
                    res = addr;
                end else begin
                    res = heap_alloc(req);
                    if (res == 0) st = efla_pkg::ST_NOSPACE;
                    else begin
                        from = addr;
                        cnt  = (req < old) ? req : old;
                        heap_free(addr);
                    end
                end
            end
        end
        r.result_address = res[17:0];
        r.copy_from      = from[17:0];
        r.copy_bytes     = cnt[18:0];
        r.status         = st;
        return r;
    endfunction

    function automatic void drop_live(int unsigned a);
        foreach (live_blocks[i]) begin
            if (live_blocks[i] == a) begin
                live_blocks.delete(i);
                return;
            end
        end
    endfunction

    // Drive one request transaction and record its expected result
    task automatic send_item(logic [1:0] k, logic [18:0] req, logic [17:0] addr);
        efla_pkg::t_result r;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_kind          = k;
        i_request_bytes = req;
        i_block_address = addr;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_op(k, 32'(req), 32'(addr));
        expected_q.push_back(r);
        case (k)
            efla_pkg::K_ALLOC: begin
                if (r.result_address != 0) live_blocks.push_back(32'(r.result_address));
            end
            efla_pkg::K_RELEASE: drop_live(32'(addr));
            efla_pkg::K_RESIZE: begin
                if (req == 0) drop_live(32'(addr));
                else if (addr == 0) begin
                    if (r.result_address != 0)
                        live_blocks.push_back(32'(r.result_address));
                end else if (r.copy_from != 0) begin
                    drop_live(32'(addr));
                    live_blocks.push_back(32'(r.result_address));
                end
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        efla_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result addr=%0d status=%0d",
                             o_result_address, o_status);
            end else begin
                want = expected_q.pop_front();
                if (o_result_address !== want.result_address ||
                    o_copy_from !== want.copy_from ||
                    o_copy_bytes !== want.copy_bytes || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d / got %0d %0d %0d %0d",
                                 want.result_address, want.copy_from, want.copy_bytes,
                                 want.status, o_result_address, o_copy_from,
                                 o_copy_bytes, o_status);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned pick_live();
        return live_blocks[$urandom_range(live_blocks.size() - 1)];
    endfunction

    // Corner requests and special cases
    task automatic test_directed();
        int unsigned a, b, c;
        send_item(efla_pkg::K_ALLOC, 19'd1, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'd24, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'd0, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'd4096, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'd262144, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'h7FFFF, 18'd0);
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'd0);
        send_item(K_UNKNOWN, 19'h7FFFF, 18'h3FFFF);
        send_item(efla_pkg::K_RESIZE, 19'd100, 18'd0);
        a = live_blocks[$];
        send_item(efla_pkg::K_RESIZE, 19'd100, 18'(a));
        send_item(efla_pkg::K_RESIZE, 19'd8, 18'(a));
        send_item(efla_pkg::K_RESIZE, 19'd20, 18'(a));
        send_item(efla_pkg::K_RESIZE, 19'd600, 18'(a));
        a = live_blocks[$];
        send_item(efla_pkg::K_RESIZE, 19'd300000, 18'(a));
        send_item(efla_pkg::K_RESIZE, 19'd0, 18'(a));
        // neighbor merges: middle, then left, then right
        send_item(efla_pkg::K_ALLOC, 19'd40, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'd40, 18'd0);
        send_item(efla_pkg::K_ALLOC, 19'd40, 18'd0);
        c = live_blocks[$]; b = live_blocks[$-1]; a = live_blocks[$-2];
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'(b));
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'(a));
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'(c));
        // near-full heap growth
        send_item(efla_pkg::K_ALLOC, 19'd200000, 18'd0);
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'(live_blocks[$]));
    endtask

    task automatic random_item();
        int          sel;
        logic [18:0] sz;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 80) sz = 19'($urandom_range(256, 1));
        else if ($urandom_range(99) < 75) sz = 19'($urandom_range(6000, 257));
        else if ($urandom_range(99) < 85) sz = 19'($urandom_range(60000, 6001));
        else sz = 19'($urandom);
        if (live_blocks.size() > MAX_LIVE && sel < 45) sel = 50;
        if (sel < 45 || (sel < 95 && live_blocks.size() == 0))
            send_item(efla_pkg::K_ALLOC, sz, 18'd0);
        else if (sel < 80) send_item(efla_pkg::K_RELEASE, 19'd0, 18'(pick_live()));
        else if (sel < 95) send_item(efla_pkg::K_RESIZE, sz, 18'(pick_live()));
        else begin
            case ($urandom_range(3))
                0: send_item(efla_pkg::K_RELEASE, 19'($urandom), 18'd0);
                1: send_item(efla_pkg::K_ALLOC, 19'd0, 18'd0);
                2: send_item(efla_pkg::K_RESIZE, sz, 18'd0);
                default: send_item(K_UNKNOWN, 19'($urandom), 18'($urandom));
            endcase
        end
    endtask

    // Random traffic through the three pressure profiles
    task automatic test_random();
        int send_pct[3] = '{16, 73, 0};
        int recv_pct[3] = '{73, 16, 0};
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (230) random_item();
        end
    endtask

    // Addresses that are not live blocks, then one plain allocate
    task automatic test_bad_address();
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'h3FFFF);
        send_item(efla_pkg::K_RELEASE, 19'd0, 18'($urandom));
        send_item(efla_pkg::K_RESIZE, 19'd64, 18'($urandom));
        send_item(efla_pkg::K_RESIZE, 19'd0, 18'h2AAAB);
        send_item(efla_pkg::K_ALLOC, 19'd64, 18'd0);
    endtask

    initial begin
        int waited;
        heap_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random();
        test_bad_address();
        waited = 0;
        while (expected_q.size() != 0 && waited < 2000000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### explicit_free_list_allocator.f
sv/efla_pkg.sv
sv/efla_mem.sv
sv/efla_seq.sv
sv/explicit_free_list_allocator.sv
bench/explicit_free_list_allocator_tb.sv
